[hdl/skeleton_junction_endpoint_detect_assert.svh]
// ----------------------------------------------------------------------------
// skeleton junction / end point detector assertion macros
// Shared assertion forms clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SKELETON_JUNCTION_ENDPOINT_DETECT_ASSERT_SVH
`define SKELETON_JUNCTION_ENDPOINT_DETECT_ASSERT_SVH

// same-cycle implication
`define SJED_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sjed assertion failed");

// next-cycle implication
`define SJED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sjed assertion failed");

`endif

[hdl/sjed_pkg.sv]
// ----------------------------------------------------------------------------
// sjed_pkg
// Types, constants and the zero-group counter shared by the skeleton
// junction / end point detector.
// ----------------------------------------------------------------------------
package sjed_pkg;

    // sizes
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int MIN_SIZE      = 3;
    localparam int ROW_W         = 10;
    localparam int POS_W         = 10;
    localparam int COUNT_W       = 3;
    localparam int PIXEL_W       = 8;
    localparam int CFG_W         = 11;
    localparam int CFG_ADDR_W    = 1;
    localparam int FLAG_W        = 2;
    localparam int WIN_W         = 9 * FLAG_W;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = CFG_ADDR_W'(1);

    // register reset values
    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = CFG_W'(480);

    // pixel codes and flag bits
    localparam logic [PIXEL_W-1:0] PIXEL_ZERO = '0;
    localparam logic [PIXEL_W-1:0] PIXEL_FULL = '1;
    localparam int FLAG_ZERO_BIT = 0;
    localparam int FLAG_FULL_BIT = 1;

    // result kinds
    localparam logic KIND_END   = 1'b0;
    localparam logic KIND_JOINT = 1'b1;

    typedef logic [FLAG_W-1:0] flags_t;
    typedef logic [WIN_W-1:0]  window_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic               kind;
        logic [COUNT_W-1:0] branch_count;
    } result_t;

    // number of 4-connected zero groups round the centre of a 3x3 window;
    // zero flag of cell (row r, column c) sits at bit c*6 + r*2
    function automatic logic [COUNT_W-1:0] count_groups(window_t win);
        logic [7:0]         z;
        logic [COUNT_W-1:0] n;
        n = '0;
        // ring order: top row left to right, right column, bottom row, left
        z = {win[2], win[4], win[10], win[16], win[14], win[12], win[6], win[0]};
        for (int i = 0; i < 8; i++) begin
            if (z[i] && !z[(i + 1) % 8]) begin
                n = n + COUNT_W'(1);
            end
        end
        if (&z) begin
            n = COUNT_W'(1);
        end
        return n;
    endfunction

endpackage

[hdl/sjed_line_store.sv]
// ----------------------------------------------------------------------------
// sjed_line_store
// Two line memories of pixel flags (previous row and the row before) with a
// registered read, write-first bypass and a clearing pass after reset.
// ----------------------------------------------------------------------------
module sjed_line_store #(
    parameter  int MAX_WIDTH = sjed_pkg::MAX_WIDTH_DEF,
    localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output sjed_pkg::flags_t     rd_above,
    output sjed_pkg::flags_t     rd_above2,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  sjed_pkg::flags_t     wr_flags,
    input  sjed_pkg::flags_t     wr_above,
    output logic                 clear_busy
);

    sjed_pkg::flags_t mem_a [MAX_WIDTH];
    sjed_pkg::flags_t mem_b [MAX_WIDTH];

    sjed_pkg::flags_t rd_a_reg;
    sjed_pkg::flags_t rd_b_reg;
    logic             clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // clearing pass over every column after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(MAX_WIDTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // memory write port
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem_a[clr_addr_reg] <= '0;
            mem_b[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem_a[wr_addr] <= wr_flags;
            mem_b[wr_addr] <= wr_above;
        end
    end

    // registered read, bypassing a write to the same column
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_a_reg <= wr_flags;
                rd_b_reg <= wr_above;
            end else begin
                rd_a_reg <= mem_a[rd_addr];
                rd_b_reg <= mem_b[rd_addr];
            end
        end
    end

    assign rd_above   = rd_a_reg;
    assign rd_above2  = rd_b_reg;
    assign clear_busy = clr_busy_reg;

endmodule

[hdl/sjed_window.sv]
// ----------------------------------------------------------------------------
// sjed_window
// 3x3 window of pixel flags and the end point / joint point classifier for
// the centre pixel.
// ----------------------------------------------------------------------------
module sjed_window #(
    parameter int COL_W = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift_en,
    input  logic [3*sjed_pkg::FLAG_W-1:0] col_flags,
    input  logic [COL_W-1:0]              x,
    input  logic [sjed_pkg::ROW_W-1:0]    y,
    output logic                          hit,
    output sjed_pkg::result_t             result
);

    sjed_pkg::window_t              window_reg;
    sjed_pkg::window_t              window_next;
    logic [sjed_pkg::COUNT_W-1:0]   n_groups;
    logic                           interior;
    logic                           centre_full;

    // new column enters at the top, oldest drops out
    assign window_next = {col_flags, window_reg[sjed_pkg::WIN_W-1:3*sjed_pkg::FLAG_W]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (shift_en) begin
            window_reg <= window_next;
        end
    end

    // classify the centre cell of the updated window
    assign n_groups    = sjed_pkg::count_groups(window_next);
    assign interior    = (x >= COL_W'(2)) && (y >= sjed_pkg::ROW_W'(2));
    assign centre_full = window_next[4 * sjed_pkg::FLAG_W + sjed_pkg::FLAG_FULL_BIT];
    assign hit = interior && centre_full &&
                 ((n_groups == sjed_pkg::COUNT_W'(1)) || (n_groups >= sjed_pkg::COUNT_W'(3)));

    always_comb begin
        result.pos_x        = sjed_pkg::POS_W'(x - COL_W'(1));
        result.pos_y        = sjed_pkg::POS_W'(y - sjed_pkg::ROW_W'(1));
        result.kind         = (n_groups >= sjed_pkg::COUNT_W'(3)) ? sjed_pkg::KIND_JOINT
                                                                  : sjed_pkg::KIND_END;
        result.branch_count = n_groups;
    end

endmodule

[hdl/skeleton_junction_endpoint_detect.sv]
// ----------------------------------------------------------------------------
// skeleton_junction_endpoint_detect
// Finds end points and joint points of a thinned binary image streamed in
// raster order, by counting zero groups round each foreground pixel.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one pixel per transaction in raster order, s_tuser marks
//   the first pixel of a frame and restarts the column and row counters.
//   m_* channel: one transaction per marked pixel, position, group count
//   and kind (m_tuser: 0 end point, 1 joint point). Pixels that mark
//   nothing and border pixels produce no transaction.
//   cfg_*: image width and height, written while the stream is idle.
// Timing:
//   one pixel per cycle sustained while m_tready keeps the output moving; the
//   edge that takes a pixel loads the input stage and reads the line memory,
//   then, once the output register can move, the classifier result is loaded
//   into it and m_tvalid rises for a marked pixel.
// Reset:
//   the line memories are cleared one column per cycle over all MAX_WIDTH
//   columns (1024 by default); s_tready stays low until the clearing ends.
// Stall:
//   a stalled m_tready holds the output register and the pixel in the
//   input stage; s_tready drops until the output register can move.
// ----------------------------------------------------------------------------
module skeleton_junction_endpoint_detect #(
    parameter int MAX_WIDTH = sjed_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel
    input  logic                            s_tuser,   // [0] frame_start
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // [9:0] pos_x, [19:10] pos_y,
                                                       // [22:20] branch_count, [23] zero
    output logic                            m_tuser,   // [0] kind
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [sjed_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [sjed_pkg::CFG_W-1:0]      cfg_wr_data
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int XW     = (WW > sjed_pkg::CFG_W) ? WW : sjed_pkg::CFG_W;
    localparam int ROW_W  = sjed_pkg::ROW_W;
    localparam int CFG_W  = sjed_pkg::CFG_W;

    // configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    // position counters
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;

    // input stage
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_x_reg;
    logic [ROW_W-1:0] s1_y_reg;
    sjed_pkg::flags_t s1_flags_reg;

    // output register
    logic              m_valid_reg;
    sjed_pkg::result_t m_result_reg;

    // control and datapath nets
    logic              accept;
    logic              out_free;
    logic              s1_adv;
    logic              clear_busy;
    logic [XW-1:0]     w_clamp;
    logic [XW-1:0]     w_raw;
    logic [CFG_W-1:0]  h_clamp;
    logic [COL_W-1:0]  col_pre;
    logic [ROW_W-1:0]  row_pre;
    logic [COL_W-1:0]  x_cur;
    logic [CFG_W-1:0]  row_inc;
    logic [ROW_W-1:0]  y_cur;
    logic [XW-1:0]     x_plus;
    logic [CFG_W-1:0]  y_plus;
    sjed_pkg::flags_t  pix_flags;
    sjed_pkg::flags_t  rd_above;
    sjed_pkg::flags_t  rd_above2;
    logic              win_hit;
    sjed_pkg::result_t win_result;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= sjed_pkg::IMAGE_WIDTH_RST;
            height_reg <= sjed_pkg::IMAGE_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                sjed_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data;
                sjed_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // clamp the frame size to the supported range
    always_comb begin
        w_raw = XW'(width_reg);
        if (w_raw < XW'(sjed_pkg::MIN_SIZE)) begin
            w_clamp = XW'(sjed_pkg::MIN_SIZE);
        end else if (w_raw > XW'(MAX_WIDTH)) begin
            w_clamp = XW'(MAX_WIDTH);
        end else begin
            w_clamp = w_raw;
        end
        if (height_reg < CFG_W'(sjed_pkg::MIN_SIZE)) begin
            h_clamp = CFG_W'(sjed_pkg::MIN_SIZE);
        end else if (height_reg > CFG_W'(sjed_pkg::MAX_HEIGHT)) begin
            h_clamp = CFG_W'(sjed_pkg::MAX_HEIGHT);
        end else begin
            h_clamp = height_reg;
        end
    end

    // position of the incoming pixel and of the one after it
    always_comb begin
        col_pre = s_tuser ? '0 : col_reg;
        row_pre = s_tuser ? '0 : row_reg;
        if (XW'(col_pre) >= w_clamp) begin
            x_cur   = '0;
            row_inc = CFG_W'(row_pre) + CFG_W'(1);
        end else begin
            x_cur   = col_pre;
            row_inc = CFG_W'(row_pre);
        end
        y_cur  = (row_inc >= h_clamp) ? '0 : row_inc[ROW_W-1:0];
        x_plus = XW'(x_cur) + XW'(1);
        y_plus = CFG_W'(y_cur) + CFG_W'(1);
        if (x_plus >= w_clamp) begin
            col_next = '0;
            row_next = (y_plus >= h_clamp) ? '0 : y_plus[ROW_W-1:0];
        end else begin
            col_next = COL_W'(x_plus);
            row_next = y_cur;
        end
    end

    // pixel flags
    always_comb begin
        pix_flags = '0;
        pix_flags[sjed_pkg::FLAG_ZERO_BIT] = (s_tdata == sjed_pkg::PIXEL_ZERO);
        pix_flags[sjed_pkg::FLAG_FULL_BIT] = (s_tdata == sjed_pkg::PIXEL_FULL);
    end

    // handshake control
    assign out_free = !m_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !clear_busy && (!s1_valid_reg || out_free);
    assign accept   = s_tvalid && s_tready;

    // counters and input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_x_reg     <= x_cur;
            s1_y_reg     <= y_cur;
            s1_flags_reg <= pix_flags;
        end
    end

    // line memories
    sjed_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (accept),
        .rd_addr    (x_cur),
        .rd_above   (rd_above),
        .rd_above2  (rd_above2),
        .wr_en      (s1_adv),
        .wr_addr    (s1_x_reg),
        .wr_flags   (s1_flags_reg),
        .wr_above   (rd_above),
        .clear_busy (clear_busy)
    );

    // window and classifier
    sjed_window #(
        .COL_W (COL_W)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (s1_adv),
        .col_flags ({s1_flags_reg, rd_above, rd_above2}),
        .x         (s1_x_reg),
        .y         (s1_y_reg),
        .hit       (win_hit),
        .result    (win_result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= win_hit;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_result_reg <= win_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_result_reg.branch_count, m_result_reg.pos_y,
                       m_result_reg.pos_x};
    assign m_tuser  = m_result_reg.kind;

    // checks
    `include "skeleton_junction_endpoint_detect_assert.svh"

    `SJED_ASSERT_NOW(a_no_accept_in_clear, clear_busy, !s_tready)
    `SJED_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid_reg)
    `SJED_ASSERT_NOW(a_kind_matches_count,
        m_valid_reg && (m_result_reg.kind == sjed_pkg::KIND_JOINT),
        m_result_reg.branch_count >= sjed_pkg::COUNT_W'(3))
    `SJED_ASSERT_NOW(a_end_has_one_group,
        m_valid_reg && (m_result_reg.kind == sjed_pkg::KIND_END),
        m_result_reg.branch_count == sjed_pkg::COUNT_W'(1))

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// skeleton_junction_endpoint_detect testbench
// Streams skeleton images through the detector: a short table of directed
// 3x3 frames, then random frames of many sizes (clamped extremes included)
// under several idling patterns. Results are compared with the table's typed
// expectations, then with a predictor of the line stores, window and group count kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_W       = sjed_pkg::MAX_WIDTH_DEF;
    localparam int PIPE_FLUSH  = 8;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_LIMIT = 3000;
    localparam int TAIL_CYCLES = 16;

    // zero-flag bit of each ring cell, top left then clockwise
    localparam int RING_BIT [8] = '{0, 6, 12, 14, 16, 10, 4, 2};

    typedef enum int {
        IDLE_NONE,
        IDLE_SOURCE,
        IDLE_SINK,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [sjed_pkg::PIXEL_W-1:0] pix;
        logic                         sof;
        logic                         typed;
        sjed_pkg::result_t            mark;
    } stim_row_t;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata     = '0;    // [7:0] pixel
    logic                            s_tuser     = 1'b0;  // [0] frame_start
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [23:0]                     m_tdata;             // [9:0] pos_x, [19:10] pos_y,
                                                          // [22:20] branch_count, [23] zero
    logic                            m_tuser;             // [0] kind
    logic                            cfg_wr_en   = 1'b0;
    logic [sjed_pkg::CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [sjed_pkg::CFG_W-1:0]      cfg_wr_data = '0;

    // predictor state
    sjed_pkg::flags_t           row_prev  [MAX_W];
    sjed_pkg::flags_t           row_prev2 [MAX_W];
    sjed_pkg::window_t          win_flags;
    int unsigned                next_col;
    int unsigned                next_row;
    logic [sjed_pkg::CFG_W-1:0] cfg_width;
    logic [sjed_pkg::CFG_W-1:0] cfg_height;

    sjed_pkg::result_t pending_marks [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int errors         = 0;
    int pixels_sent    = 0;
    int marks_seen     = 0;
    int joints_seen    = 0;
    int settings_used  = 0;

    // directed frames at 3x3: lone dot, tee joint after a frame wrap, plain line
    stim_row_t directed_rows [27] = '{
        '{8'h00, 1'b1, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{10'd1, 10'd1, sjed_pkg::KIND_END, 3'd1}},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{10'd1, 10'd1, sjed_pkg::KIND_JOINT, 3'd3}},
        '{8'h00, 1'b1, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}
    };

    skeleton_junction_endpoint_detect dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // 8 ns clock
    always begin
        #4;
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic int unsigned clamp_size(input logic [sjed_pkg::CFG_W-1:0] v,
                                               input int unsigned hi);
        if (v < sjed_pkg::MIN_SIZE) return sjed_pkg::MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the predicted line stores and window by one pixel
    function automatic bit classify_pixel(input logic [sjed_pkg::PIXEL_W-1:0] pix,
                                          input logic sof,
                                          output sjed_pkg::result_t mark);
        int unsigned      w, h, x, y, groups;
        sjed_pkg::flags_t fl, up1, up2;
        logic [7:0]       ring;
        bit               found;
        mark = '0;
        w = clamp_size(cfg_width, MAX_W);
        h = clamp_size(cfg_height, sjed_pkg::MAX_HEIGHT);
        if (sof) begin
            next_col = 0;
            next_row = 0;
        end
        if (next_col >= w) begin
            next_col = 0;
            next_row++;
        end
        if (next_row >= h) next_row = 0;
        x = next_col;
        y = next_row;

        fl = {pix == sjed_pkg::PIXEL_FULL, pix == sjed_pkg::PIXEL_ZERO};
        up1 = row_prev[x];
        up2 = row_prev2[x];
        row_prev2[x] = up1;
        row_prev[x] = fl;
        win_flags = {fl, up1, up2, win_flags[sjed_pkg::WIN_W-1:6]};

        // zero groups: zero cells followed by a non-zero cell going round
        for (int i = 0; i < 8; i++) ring[i] = win_flags[RING_BIT[i]];
        groups = 0;
        for (int i = 0; i < 8; i++) begin
            if (ring[i] && !ring[(i + 1) % 8]) groups++;
        end
        if (ring == 8'hFF) groups = 1;

        found = (x >= 2) && (y >= 2) && win_flags[8 + sjed_pkg::FLAG_FULL_BIT] &&
                (groups == 1 || groups >= 3);
        if (found) begin
            mark.pos_x        = sjed_pkg::POS_W'(x - 1);
            mark.pos_y        = sjed_pkg::POS_W'(y - 1);
            mark.kind         = (groups >= 3) ? sjed_pkg::KIND_JOINT : sjed_pkg::KIND_END;
            mark.branch_count = sjed_pkg::COUNT_W'(groups);
        end

        next_col = x + 1;
        if (next_col >= w) begin
            next_col = 0;
            next_row = y + 1;
            if (next_row >= h) next_row = 0;
        end
        return found;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 10) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // append one expected result
    function automatic void queue_mark(input sjed_pkg::result_t m);
        pending_marks = {pending_marks, m};
    endfunction

    // mostly 0 and 255, some arbitrary values
    function automatic logic [sjed_pkg::PIXEL_W-1:0] skeleton_pixel();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return sjed_pkg::PIXEL_ZERO;
        if (r < 85) return sjed_pkg::PIXEL_FULL;
        return sjed_pkg::PIXEL_W'($urandom_range(0, 255));
    endfunction

    // one input transaction, then its predicted result (or the typed one)
    task automatic send_pixel(input logic [sjed_pkg::PIXEL_W-1:0] pix, input logic sof,
                              input logic typed, input sjed_pkg::result_t typed_mark);
        sjed_pkg::result_t mark;
        bit                found;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= sof;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        found = classify_pixel(pix, sof, mark);
        if (typed) queue_mark(typed_mark);
        else if (found) queue_mark(mark);
    endtask

    // sender holds off until every expected result is out and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_marks.size() != 0) @(posedge aclk);
        repeat (PIPE_FLUSH) @(posedge aclk);
    endtask

    task automatic set_frame_size(input logic [sjed_pkg::CFG_W-1:0] w_val,
                                  input logic [sjed_pkg::CFG_W-1:0] h_val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= sjed_pkg::REG_IMAGE_WIDTH;
        cfg_wr_data <= w_val;
        @(posedge aclk);
        cfg_addr    <= sjed_pkg::REG_IMAGE_HEIGHT;
        cfg_wr_data <= h_val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        cfg_width  = w_val;
        cfg_height = h_val;
        settings_used++;
    endtask

    // random frames at one size; the last frame may be cut short
    task automatic run_phase(input logic [sjed_pkg::CFG_W-1:0] w_val,
                             input logic [sjed_pkg::CFG_W-1:0] h_val,
                             input int n_items, input idle_mode_t mode);
        int unsigned full_len, frame_len, frame_pos;
        logic        sof;
        settle();
        set_frame_size(w_val, h_val);
        case (mode)
            IDLE_NONE:   begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SOURCE: begin src_idle_pct = 88; sink_stall_pct = 0;  end
            IDLE_SINK:   begin src_idle_pct = 0;  sink_stall_pct = 88; end
            default:     begin src_idle_pct = 36; sink_stall_pct = 36; end
        endcase
        full_len  = clamp_size(w_val, MAX_W) * clamp_size(h_val, sjed_pkg::MAX_HEIGHT);
        frame_len = full_len;
        frame_pos = 0;
        // first frame may carry on from the old counters at the new size
        sof = 1'($urandom_range(0, 1));
        for (int i = 0; i < n_items; i++) begin
            if (frame_pos == frame_len) begin
                frame_pos = 0;
                frame_len = ($urandom_range(0, 99) < 80) ? full_len : $urandom_range(1, full_len);
                sof = ($urandom_range(0, 99) < 90);
            end else if (i != 0) begin
                sof = 1'b0;
            end
            if ($urandom_range(0, 149) == 0) settle();
            send_pixel(skeleton_pixel(), sof, 1'b0, '0);
            frame_pos++;
        end
    endtask

    // result transaction check against the oldest expectation
    always @(posedge aclk) begin : result_check
        sjed_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            marks_seen++;
            if (m_tuser == sjed_pkg::KIND_JOINT) joints_seen++;
            if (pending_marks.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d count=%0d kind=%0d",
                                          m_tdata[9:0], m_tdata[19:10], m_tdata[22:20],
                                          m_tuser));
            end else begin
                want = pending_marks.pop_front();
                if (m_tdata[9:0] !== want.pos_x || m_tdata[19:10] !== want.pos_y ||
                    m_tdata[22:20] !== want.branch_count || m_tdata[23] !== 1'b0 ||
                    m_tuser !== want.kind) begin
                    report_mismatch($sformatf(
                        "expected x=%0d y=%0d n=%0d k=%0d, got x=%0d y=%0d n=%0d k=%0d pad=%0b",
                        want.pos_x, want.pos_y, want.branch_count, want.kind,
                        m_tdata[9:0], m_tdata[19:10], m_tdata[22:20], m_tuser, m_tdata[23]));
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int waited;
        // predictor reset
        for (int i = 0; i < MAX_W; i++) begin
            row_prev[i]  = '0;
            row_prev2[i] = '0;
        end
        win_flags  = '0;
        next_col   = 0;
        next_row   = 0;
        cfg_width  = sjed_pkg::IMAGE_WIDTH_RST;
        cfg_height = sjed_pkg::IMAGE_HEIGHT_RST;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table at the smallest frame
        set_frame_size(sjed_pkg::CFG_W'(3), sjed_pkg::CFG_W'(3));
        foreach (directed_rows[i]) begin
            send_pixel(directed_rows[i].pix, directed_rows[i].sof,
                       directed_rows[i].typed, directed_rows[i].mark);
        end

        // random frames, out-of-range sizes included
        run_phase(sjed_pkg::CFG_W'(5),    sjed_pkg::CFG_W'(4),    70, IDLE_NONE);
        run_phase(sjed_pkg::CFG_W'(8),    sjed_pkg::CFG_W'(5),    80, IDLE_SOURCE);
        run_phase(sjed_pkg::CFG_W'(1),    sjed_pkg::CFG_W'(2047), 70, IDLE_SINK);
        run_phase(sjed_pkg::CFG_W'(2),    sjed_pkg::CFG_W'(0),    70, IDLE_BOTH);
        run_phase(sjed_pkg::CFG_W'(16),   sjed_pkg::CFG_W'(3),    80, IDLE_NONE);
        run_phase(sjed_pkg::CFG_W'(4),    sjed_pkg::CFG_W'(9),    70, IDLE_SOURCE);
        run_phase(sjed_pkg::CFG_W'(11),   sjed_pkg::CFG_W'(7),    70, IDLE_SINK);
        run_phase(sjed_pkg::CFG_W'(6),    sjed_pkg::CFG_W'(6),    70, IDLE_BOTH);
        // widest and tallest sizes, a short stretch of each
        run_phase(sjed_pkg::CFG_W'(2047), sjed_pkg::CFG_W'(3),    20, IDLE_NONE);
        run_phase(sjed_pkg::CFG_W'(3),    sjed_pkg::CFG_W'(1024), 20, IDLE_BOTH);

        // drain, then a quiet tail to catch stray results
        s_tvalid <= 1'b0;
        @(posedge aclk);
        waited = 0;
        while (pending_marks.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_marks.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_marks.size()));
        end

        $display("run covered %0d pixels over %0d frame sizes, %0d marks checked (%0d joints)",
                 pixels_sent, settings_used, marks_seen, joints_seen);
        $display("idling: none, sender only, receiver only and both; %0d mismatches", errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/sjed_pkg.sv
hdl/sjed_line_store.sv
hdl/sjed_window.sv
hdl/skeleton_junction_endpoint_detect.sv
verif/testbench.sv
